>>> rtl/svs_pkg.sv
// Shared types and constants for the sound channel voice stealer.
`timescale 1ns / 1ps

package svs_pkg;

    localparam int CHANNELS = 32;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int ENT_W   = 16;
    localparam int SUB_W   = 9;
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 24;
    localparam int REL_W   = 5;
    localparam int CHIDX_W = 5;
    localparam int ACT_W   = 6;

    // Compare width for cell index against active count
    localparam int ACT_CMP_W = ((IDX_W > ACT_W) ? IDX_W : ACT_W) + 1;

    // Highest sub-channel that may be overridden
    localparam logic [SUB_W-1:0] SUB_SINGLE_MAX = SUB_W'(255);

    // Stream payload widths
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LISTENER = CFG_IDX_W'(1);

    localparam logic [ACT_W-1:0] ACTIVE_RESET   = ACT_W'(32);
    localparam logic [ENT_W-1:0] LISTENER_RESET = '0;

    typedef enum logic [OP_W-1:0] {
        OP_PLAY     = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_STOP_ALL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } ctl_state_t;

    // Request fields seen by every cell during a scan
    typedef struct packed {
        logic [ENT_W-1:0]  ent;
        logic [SUB_W-1:0]  sub;
        logic [TIME_W-1:0] now;
        logic [ENT_W-1:0]  lis;
    } req_t;

    // Running scan result handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic              stop;
        logic              refused;
        logic              pick_busy;
        logic [IDX_W-1:0]  pick;
        logic [TIME_W-1:0] life;
    } scan_t;

    // Table update broadcast to the cells
    typedef struct packed {
        logic              set;
        logic              clr_one;
        logic              clr_all;
        logic [IDX_W-1:0]  idx;
        logic [ENT_W-1:0]  owner;
        logic [SUB_W-1:0]  sub;
        logic [TIME_W-1:0] end_time;
    } wr_t;

endpackage

>>> rtl/svs_cell.sv
// One channel entry of the table and its step of the allocation scan.
`timescale 1ns / 1ps

module svs_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [svs_pkg::IDX_W-1:0]  cell_idx,
    input  logic [svs_pkg::ACT_W-1:0]  active_channels,
    input  svs_pkg::req_t              req,
    input  svs_pkg::wr_t               wr,
    input  svs_pkg::scan_t             scan_in,
    output svs_pkg::scan_t             scan_out
);
    import svs_pkg::*;

    logic              busy_reg;
    logic [ENT_W-1:0]  owner_reg;
    logic [SUB_W-1:0]  sub_reg;
    logic [TIME_W-1:0] end_reg;
    scan_t             scan_reg;
    scan_t             scan_next;

    logic              in_range;
    logic              match;
    logic              protect;
    logic              hit;
    logic [TIME_W-1:0] rem;

    assign hit = (wr.idx == cell_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (wr.clr_all || (wr.clr_one && hit)) begin
            busy_reg <= 1'b0;
        end else if (wr.set && hit) begin
            busy_reg <= 1'b1;
        end
    end

    // owner/sub/end are only read while busy
    always_ff @(posedge aclk) begin
        if (wr.set && hit) begin
            owner_reg <= wr.owner;
            sub_reg   <= wr.sub;
            end_reg   <= wr.end_time;
        end
    end

    always_comb begin
        in_range  = (ACT_CMP_W'(cell_idx) < ACT_CMP_W'(active_channels));
        match     = (req.sub != '0) && (owner_reg == req.ent) && (sub_reg == req.sub);
        protect   = (owner_reg == req.lis) && (req.ent != req.lis);
        rem       = end_reg - req.now;
        scan_next = scan_in;
        if (in_range && !scan_in.stop) begin
            if (!busy_reg) begin
                // first idle channel, unless a zero-remaining candidate exists
                if (scan_in.life != '0) begin
                    scan_next.pick      = cell_idx;
                    scan_next.found     = 1'b1;
                    scan_next.life      = '0;
                    scan_next.pick_busy = 1'b0;
                end
            end else if (match) begin
                scan_next.stop = 1'b1;
                if (req.sub > SUB_SINGLE_MAX) begin
                    scan_next.refused = 1'b1;
                end else begin
                    scan_next.pick      = cell_idx;
                    scan_next.found     = 1'b1;
                    scan_next.pick_busy = 1'b1;
                end
            end else if (!protect && (rem < scan_in.life)) begin
                scan_next.pick      = cell_idx;
                scan_next.found     = 1'b1;
                scan_next.life      = rem;
                scan_next.pick_busy = 1'b1;
            end
        end
    end

    // token valid is reset; the carried scan state only loads with a token
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg.valid <= 1'b0;
        end else begin
            scan_reg.valid <= scan_in.valid;
        end
        if (scan_in.valid) begin
            scan_reg.found     <= scan_next.found;
            scan_reg.stop      <= scan_next.stop;
            scan_reg.refused   <= scan_next.refused;
            scan_reg.pick_busy <= scan_next.pick_busy;
            scan_reg.pick      <= scan_next.pick;
            scan_reg.life      <= scan_next.life;
        end
    end

    assign scan_out = scan_reg;

endmodule

>>> rtl/sound_channel_voice_stealer.sv
// Top level: mixer channel allocator with voice stealing over a chain of channel cells.
`timescale 1ns / 1ps

// Channel  | Direction | Payload
// s_       | in        | tuser[1:0] operation; tdata entity, ent_channel, now, duration,
//          |           |   release_index
// m_       | out       | tdata granted, channel_index, stole_busy
// cfg_     | in        | cfg_index register number, cfg_data value
//
// Sequence: a play item's accept launches the scan token through a register; the
// token walks the chain of cells, one cell a cycle; the controller then moves to
// the update state, which updates the table and loads the result register once
// that register is free. Release and stop-all skip the walk and go straight to
// the update state. The input is ready again only once the controller is back in
// idle, so one item is in flight at a time.
// Reset: aresetn low synchronously idles every channel and restores
// active_channels = 32, listener_entity = 0; no item or write is taken in reset.
// Stalls: a result waits in the output register while the next item is
// captured; the table update holds until that register is free.

module sound_channel_voice_stealer (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] entity, [24:16] ent_channel, [56:25] now, [80:57] duration,
    // [85:81] release_index, [87:86] zero
    input  logic [svs_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] operation
    input  logic [svs_pkg::OP_W-1:0]        s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] granted, [5:1] channel_index, [6] stole_busy, [7] zero
    output logic [svs_pkg::M_TDATA_W-1:0]   m_tdata,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [svs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svs_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import svs_pkg::*;

    ctl_state_t        state_reg, state_next;

    // captured request
    op_t               op_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic [SUB_W-1:0]  sub_reg;
    logic [TIME_W-1:0] now_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic [REL_W-1:0]  rel_reg;

    logic [ACT_W-1:0]  active_reg;
    logic [ENT_W-1:0]  listener_reg;

    logic              launch_reg;
    logic              out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic              accept;
    logic              out_free;
    logic              finish;
    logic              granted;

    req_t              req;
    wr_t               wr;
    scan_t             link [CHANNELS+1];
    logic [CHANNELS-1:0] link_valid;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = aresetn;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= ACTIVE_RESET;
            listener_reg <= LISTENER_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ACTIVE:   active_reg   <= cfg_data[ACT_W-1:0];
                REG_LISTENER: listener_reg <= cfg_data[ENT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- request capture ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= op_t'(s_tuser);
            ent_reg <= s_tdata[15:0];
            sub_reg <= s_tdata[24:16];
            now_reg <= s_tdata[56:25];
            dur_reg <= s_tdata[80:57];
            rel_reg <= s_tdata[85:81];
        end
    end

    // ---------------- control FSM ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= accept && (op_t'(s_tuser) == OP_PLAY);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (op_t'(s_tuser) == OP_PLAY) ? ST_SCAN : ST_WRITE;
                end
            end
            ST_SCAN: begin
                if (link[CHANNELS].valid) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // scan result at the far end of the chain holds until the next walk
    assign granted = link[CHANNELS].found && !link[CHANNELS].refused;

    always_comb begin
        s_tready      = 1'b0;
        finish        = 1'b0;
        wr            = '0;
        wr.owner      = ent_reg;
        wr.sub        = sub_reg;
        wr.end_time   = now_reg + TIME_W'(dur_reg);
        wr.idx        = link[CHANNELS].pick;
        out_data_next = '0;
        unique case (state_reg)
            ST_IDLE:  s_tready = aresetn;
            ST_SCAN:  ;
            ST_WRITE: begin
                finish = out_free;
                case (op_reg)
                    OP_PLAY: begin
                        wr.set = out_free && granted;
                        if (granted) begin
                            out_data_next[0]   = 1'b1;
                            out_data_next[5:1] = CHIDX_W'(link[CHANNELS].pick);
                            out_data_next[6]   = link[CHANNELS].pick_busy;
                        end
                    end
                    OP_RELEASE: begin
                        wr.idx     = IDX_W'(rel_reg);
                        wr.clr_one = out_free && (32'(rel_reg) < CHANNELS);
                    end
                    OP_STOP_ALL: wr.clr_all = out_free;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // ---------------- result register ----------------
    always_comb begin
        out_valid_next = out_valid_reg;
        if (finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- chain of channel cells ----------------
    assign req.ent = ent_reg;
    assign req.sub = sub_reg;
    assign req.now = now_reg;
    assign req.lis = listener_reg;

    // fresh token: nothing found, remaining-time bound at its maximum
    always_comb begin
        link[0]       = '0;
        link[0].valid = launch_reg;
        link[0].life  = '1;
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        svs_cell u_cell (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .cell_idx        (IDX_W'(g)),
            .active_channels (active_reg),
            .req             (req),
            .wr              (wr),
            .scan_in         (link[g]),
            .scan_out        (link[g+1])
        );
        assign link_valid[g] = link[g+1].valid;
    end

`ifndef SYNTHESIS
    // a single token walks the chain
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(link_valid))
        else $error("more than one scan token in the cell chain");

    // the token reaches the end only while the controller waits for it
    a_end_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        link[CHANNELS].valid |-> state_reg == ST_SCAN)
        else $error("scan finished outside the scan state");

    // a refused or empty result carries no channel
    a_clean_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[6:1] == '0))
        else $error("result not granted but fields set");

    // an accepted item leaves idle at once
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("controller stayed idle after an accepted item");

    // table changes only while finishing an item
    a_write_when_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.set || wr.clr_one || wr.clr_all) |-> finish)
        else $error("table written outside the update step");
`endif

endmodule
